### hdl/lfcf_pkg.sv
// lfcf_pkg: shared types and constants of the length/crc32 frame builder
// depends on: nothing

package lfcf_pkg;

    // crc-32 polynomial, msb first, no reflection
    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;

    // byte kind codes on the frame channel
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_TRAILER = 2'd2;

    // one payload transfer
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic [15:0] payload_length;
    } item_t;

    // one frame byte transfer
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] byte_kind;
        logic       run_end;
        logic       frame_end;
    } frame_byte_t;

    // emitter to output register
    typedef struct packed {
        logic        load;
        frame_byte_t data;
    } emit_t;

    // which byte of the current item goes out next
    typedef enum logic [2:0] {
        PH_START,
        PH_HDR_HI,
        PH_HDR_LO,
        PH_DATA,
        PH_CRC3,
        PH_CRC2,
        PH_CRC1,
        PH_CRC0
    } phase_t;

endpackage

### hdl/lfcf_if.sv
// lfcf_item_if / lfcf_frame_if: valid/ready channels of the frame builder
// depends on: nothing

interface lfcf_item_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] payload_length;

    modport source (output valid, data_byte, first_byte, last_byte, payload_length,
                    input ready);
    modport sink   (input valid, data_byte, first_byte, last_byte, payload_length,
                    output ready);
endinterface

interface lfcf_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] byte_kind;
    logic       run_end;
    logic       frame_end;

    modport source (output valid, out_byte, byte_kind, run_end, frame_end,
                    input ready);
    modport sink   (input valid, out_byte, byte_kind, run_end, frame_end,
                    output ready);
endinterface

### hdl/lfcf_in_reg.sv
// lfcf_in_reg: holding register for the payload transfer being framed
// depends on: lfcf_pkg, lfcf_item_if

module lfcf_in_reg (
    input  logic           clk,
    input  logic           rst_n,
    lfcf_item_if.sink      payload,
    input  logic           take,
    output logic           item_valid,
    output lfcf_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    lfcf_pkg::item_t item_reg;
    logic            accept;

    // room when empty or when the held item leaves this cycle
    assign payload.ready = !valid_reg || take;
    assign accept        = payload.valid && payload.ready;

    // valid flag
    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.data_byte      <= payload.data_byte;
            item_reg.first_byte     <= payload.first_byte;
            item_reg.last_byte      <= payload.last_byte;
            item_reg.payload_length <= payload.payload_length;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### hdl/lfcf_emitter.sv
// lfcf_emitter: byte sequencer and running crc-32 of the frame builder
// depends on: lfcf_pkg

module lfcf_emitter (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    input  lfcf_pkg::item_t item,
    input  logic            space,
    output logic            take,
    output lfcf_pkg::emit_t emit
);

    lfcf_pkg::phase_t phase_reg;
    lfcf_pkg::phase_t phase_next;
    lfcf_pkg::phase_t cur;
    logic [31:0]      crc_reg;
    logic [31:0]      crc_next;
    logic [31:0]      crc_fed;
    logic [31:0]      crc_base;
    logic             load;
    logic             done;

    // one byte into the crc, eight shift steps
    function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'h000000};
        for (int k = 0; k < 8; k++)
        begin
            if (c[31])
            begin
                c = {c[30:0], 1'b0} ^ lfcf_pkg::CRC_POLY;
            end
            else
            begin
                c = {c[30:0], 1'b0};
            end
        end
        return c;
    endfunction

    assign load = item_valid && space;

    // byte about to go out
    assign cur = (phase_reg != lfcf_pkg::PH_START) ? phase_reg :
                 (item.first_byte ? lfcf_pkg::PH_HDR_HI : lfcf_pkg::PH_DATA);

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        if (load)
        begin
            unique case (cur)
                lfcf_pkg::PH_HDR_HI: phase_next = lfcf_pkg::PH_HDR_LO;
                lfcf_pkg::PH_HDR_LO: phase_next = lfcf_pkg::PH_DATA;
                lfcf_pkg::PH_DATA:   phase_next = item.last_byte ? lfcf_pkg::PH_CRC3
                                                                 : lfcf_pkg::PH_START;
                lfcf_pkg::PH_CRC3:   phase_next = lfcf_pkg::PH_CRC2;
                lfcf_pkg::PH_CRC2:   phase_next = lfcf_pkg::PH_CRC1;
                lfcf_pkg::PH_CRC1:   phase_next = lfcf_pkg::PH_CRC0;
                default:             phase_next = lfcf_pkg::PH_START;
            endcase
        end
    end

    assign done = load && (phase_next == lfcf_pkg::PH_START);
    assign take = done;

    // outputs: frame byte and crc update
    always_comb
    begin
        emit.load           = load;
        emit.data.run_end   = done;
        emit.data.frame_end = 1'b0;
        emit.data.byte_kind = lfcf_pkg::KIND_TRAILER;
        emit.data.out_byte  = 8'h00;
        crc_base            = crc_reg;
        unique case (cur)
            lfcf_pkg::PH_HDR_HI:
            begin
                emit.data.out_byte  = item.payload_length[15:8];
                emit.data.byte_kind = lfcf_pkg::KIND_HEADER;
                crc_base            = 32'h0000_0000;
            end
            lfcf_pkg::PH_HDR_LO:
            begin
                emit.data.out_byte  = item.payload_length[7:0];
                emit.data.byte_kind = lfcf_pkg::KIND_HEADER;
            end
            lfcf_pkg::PH_DATA:
            begin
                emit.data.out_byte  = item.data_byte;
                emit.data.byte_kind = lfcf_pkg::KIND_PAYLOAD;
            end
            lfcf_pkg::PH_CRC3: emit.data.out_byte = crc_reg[31:24];
            lfcf_pkg::PH_CRC2: emit.data.out_byte = crc_reg[23:16];
            lfcf_pkg::PH_CRC1: emit.data.out_byte = crc_reg[15:8];
            lfcf_pkg::PH_CRC0:
            begin
                emit.data.out_byte  = crc_reg[7:0];
                emit.data.frame_end = 1'b1;
            end
            default: emit.data.out_byte = 8'h00;
        endcase
    end

    assign crc_fed = crc_feed(crc_base, emit.data.out_byte);

    // header and payload bytes extend the crc, the last trailer byte clears it
    always_comb
    begin
        crc_next = crc_reg;
        if (load)
        begin
            priority if (emit.data.byte_kind != lfcf_pkg::KIND_TRAILER)
            begin
                crc_next = crc_fed;
            end
            else if (emit.data.frame_end)
            begin
                crc_next = 32'h0000_0000;
            end
            else
            begin
                crc_next = crc_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= lfcf_pkg::PH_START;
            crc_reg   <= 32'h0000_0000;
        end
        else
        begin
            phase_reg <= phase_next;
            crc_reg   <= crc_next;
        end
    end

    // checks
    a_frame_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        load && emit.data.frame_end |-> emit.data.run_end)
        else $error("frame end without run end");

    a_crc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        load && cur == lfcf_pkg::PH_CRC0 |=> crc_reg == 32'h0000_0000)
        else $error("crc not cleared after trailer");

    a_header_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        load && cur == lfcf_pkg::PH_HDR_HI |-> item.first_byte)
        else $error("header emitted without first byte");

    a_stall_holds_phase: assert property (@(posedge clk) disable iff (!rst_n)
        !load |=> $stable(phase_reg))
        else $error("phase moved while stalled");

endmodule

### hdl/lfcf_out_reg.sv
// lfcf_out_reg: output register of the frame byte channel
// depends on: lfcf_pkg, lfcf_frame_if

module lfcf_out_reg (
    input  logic            clk,
    input  logic            rst_n,
    input  lfcf_pkg::emit_t emit,
    output logic            space,
    lfcf_frame_if.source    frame
);

    logic                  valid_reg;
    logic                  valid_next;
    lfcf_pkg::frame_byte_t data_reg;

    // free when empty or the held byte leaves this cycle
    assign space = !valid_reg || frame.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (emit.load)
        begin
            valid_next = 1'b1;
        end
        else if (frame.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (emit.load)
        begin
            data_reg <= emit.data;
        end
    end

    assign frame.valid     = valid_reg;
    assign frame.out_byte  = data_reg.out_byte;
    assign frame.byte_kind = data_reg.byte_kind;
    assign frame.run_end   = data_reg.run_end;
    assign frame.frame_end = data_reg.frame_end;

endmodule

### hdl/length_crc32_frame_builder.sv
// length_crc32_frame_builder: top level of the length-prefixed crc-32 framer
// depends on: lfcf_pkg, lfcf_if, lfcf_in_reg, lfcf_emitter, lfcf_out_reg

// Payload bytes enter on the payload channel and frame bytes leave on the frame
// channel, one byte per transfer. A transfer with first_byte set is preceded by
// a two-byte big-endian length header; one with last_byte set is followed by a
// four-byte big-endian crc-32 (poly 0x04C11DB7, msb first, init 0, no final
// xor) over header and payload. An item holds the emitter for its data byte,
// plus the header bytes if first_byte and the crc bytes if last_byte is set,
// since a single output register takes one frame byte per cycle while the
// frame channel is ready; plain payload bytes then stream at one per cycle.
// An input holding register and the output register decouple the channels,
// so a new payload byte is taken while the previous frame byte still waits.
// The first frame byte of an item passes the input, then the output register.

module length_crc32_frame_builder (
    input  logic         clk,
    input  logic         rst_n,
    lfcf_item_if.sink    payload,
    lfcf_frame_if.source frame
);

    logic            item_valid;
    lfcf_pkg::item_t item;
    logic            take;
    logic            space;
    lfcf_pkg::emit_t emit;

    lfcf_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .payload    (payload),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    lfcf_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .space      (space),
        .take       (take),
        .emit       (emit)
    );

    lfcf_out_reg u_out_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .emit  (emit),
        .space (space),
        .frame (frame)
    );

endmodule
